// ===== rtl/entry_id_hash_index_defines.svh =====
// Assertion macros shared by the hash index modules.
// No dependencies.
`ifndef ENTRY_ID_HASH_INDEX_DEFINES_SVH
`define ENTRY_ID_HASH_INDEX_DEFINES_SVH
// Implication checked on each rising edge outside reset.
`define EIH_ASSERT_IMP(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define EIH_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed");
`endif

// ===== rtl/eih_pkg.sv =====
// Types and constants of the entry id hash index.
// No dependencies.
package eih_pkg;
   localparam logic [31:0] HASH_START = 32'd2166136261;
   localparam logic [31:0] HASH_PRIME = 32'd16777619;
   localparam logic OP_LOOKUP = 1'b0;
   localparam logic OP_INSERT = 1'b1;
   localparam logic [2:0] ST_HIT     = 3'd0;
   localparam logic [2:0] ST_MISS    = 3'd1;
   localparam logic [2:0] ST_NEW     = 3'd2;
   localparam logic [2:0] ST_UPDATED = 3'd3;
   localparam logic [2:0] ST_FULL    = 3'd4;

   typedef struct packed {
      logic        opcode;
      logic [31:0] key_package;
      logic [31:0] key_entry;
      logic [9:0]  store_value;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [9:0] found_value;
   } rsp_type;

   // Item in the queue between hashing front and probing back.
   typedef struct packed {
      req_type     req;
      logic [31:0] hash;
   } job_type;
endpackage

// ===== rtl/eih_front.sv =====
// Front part: accepts requests and computes the FNV-1a style hash.
// Depends on eih_pkg.
module eih_front import eih_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    job_valid,
   input  logic    job_ready,
   output job_type job_data
);
   // Steps: 0 idle, 1 first multiply, 2 second multiply, 3 holding result.
   localparam logic [1:0] F_IDLE = 2'd0, F_MUL1 = 2'd1, F_MUL2 = 2'd2, F_DONE = 2'd3;
   logic [1:0]  state_ff, state_in;
   req_type     req_ff, req_in;
   logic [31:0] hash_ff, hash_in;

   assign req_ready = (state_ff == F_IDLE);
   assign job_valid = (state_ff == F_DONE);
   assign job_data  = '{req: req_ff, hash: hash_ff};

   always_comb begin
      state_in = state_ff;
      req_in   = req_ff;
      hash_in  = hash_ff;
      case (state_ff)
         F_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = F_MUL1;
            end
         end
         F_MUL1: begin
            hash_in  = (HASH_START ^ req_ff.key_package) * HASH_PRIME;
            state_in = F_MUL2;
         end
         F_MUL2: begin
            hash_in  = (hash_ff ^ req_ff.key_entry) * HASH_PRIME;
            state_in = F_DONE;
         end
         F_DONE: begin
            if (job_ready) state_in = F_IDLE;
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= F_IDLE;
      else state_ff <= state_in;
      req_ff  <= req_in;
      hash_ff <= hash_in;
   end
endmodule

// ===== rtl/eih_queue.sv =====
// Two-entry queue between the front and the back.
// Depends on eih_pkg and the assertion macros.
`include "entry_id_hash_index_defines.svh"
module eih_queue import eih_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  job_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output job_type out_data
);
   job_type    mem_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic       push, pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_data  = mem_ff[rp_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (pop) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
      if (push) mem_ff[wp_ff] <= in_data;
   end

   `EIH_ASSERT_IMP(a_cnt_range, clock, reset, 1'b1, cnt_ff <= 2'd2)
   `EIH_ASSERT_NEXT(a_push_only, clock, reset, push && !pop, cnt_ff == $past(cnt_ff) + 2'd1)
   `EIH_ASSERT_IMP(a_ptr_match, clock, reset, cnt_ff == 2'd0 || cnt_ff == 2'd2, wp_ff == rp_ff)
endmodule

// ===== rtl/eih_back.sv =====
// Back part: modulo by capacity, then linear probing of the slot memory.
// Depends on eih_pkg and the assertion macros.
`include "entry_id_hash_index_defines.svh"
module eih_back import eih_pkg::*; #(
   parameter int DEPTH = 1024,
   parameter int AW = 10,
   parameter int CW = 11
) (
   input  logic          clock,
   input  logic          reset,
   input  logic [CW-1:0] cap,
   input  logic          job_valid,
   output logic          job_ready,
   input  job_type       job_data,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output rsp_type       rsp_data
);
   localparam logic [3:0] B_IDLE = 4'd0, B_MOD = 4'd1, B_RD = 4'd2, B_WAIT = 4'd3,
      B_CHK = 4'd4, B_OUT = 4'd5, B_CLR = 4'd6;
   localparam int KW = 64 + 10;
   localparam int MW = KW + 1;
   localparam int HC = 32 + CW;

   logic [3:0]    state_ff, state_in;
   job_type       job_ff;
   logic [HC-1:0] rem_ff, rem_in;   // remainder under restoring division
   logic [5:0]    bit_ff, bit_in;
   logic [CW-1:0] idx_ff, idx_in, n_ff, n_in;
   logic [AW-1:0] clr_ff, clr_in;
   rsp_type       rsp_ff, rsp_in;
   // Each slot holds its valid mark in the top bit, then the key and the value.
   logic [MW-1:0] mem [DEPTH];
   logic [MW-1:0] rd_ff;
   logic          wr_en;
   logic [MW-1:0] wr_data;
   logic [HC-1:0] trial;
   logic [AW-1:0] addr;

   assign addr      = (state_ff == B_CLR) ? clr_ff : idx_ff[AW-1:0];
   assign job_ready = (state_ff == B_IDLE);
   assign rsp_valid = (state_ff == B_OUT);
   assign rsp_data  = rsp_ff;
   assign trial     = {rem_ff[HC-2:0], job_ff.hash[bit_ff[4:0]]};

   always_comb begin
      state_in  = state_ff;
      rem_in    = rem_ff;
      bit_in    = bit_ff;
      idx_in    = idx_ff;
      n_in      = n_ff;
      clr_in    = clr_ff;
      rsp_in    = rsp_ff;
      wr_en     = 1'b0;
      wr_data   = {1'b1, job_ff.req.key_package, job_ff.req.key_entry,
                   job_ff.req.store_value};
      case (state_ff)
         B_CLR: begin
            wr_en   = 1'b1;
            wr_data = '0;
            clr_in  = clr_ff + AW'(1);
            if (clr_ff == AW'(DEPTH - 1)) state_in = B_IDLE;
         end
         B_IDLE: begin
            if (job_valid) begin
               rem_in = '0;
               bit_in = 6'd31;
               n_in   = '0;
               rsp_in = '{status: (job_data.req.opcode == OP_INSERT) ? ST_FULL : ST_MISS,
                          found_value: '0};
               state_in = (cap == '0) ? B_OUT : B_MOD;
            end
         end
         B_MOD: begin
            rem_in = (trial >= HC'(cap)) ? trial - HC'(cap) : trial;
            bit_in = bit_ff - 6'd1;
            if (bit_ff == 6'd0) begin
               idx_in   = rem_in[CW-1:0];
               state_in = B_RD;
            end
         end
         B_RD: state_in = B_WAIT;
         B_WAIT: state_in = B_CHK;
         B_CHK: begin
            if (n_ff >= cap || idx_ff >= CW'(DEPTH)) begin
               state_in = B_OUT;
            end else if (!rd_ff[KW]) begin
               if (job_ff.req.opcode == OP_INSERT) begin
                  wr_en = 1'b1;
                  rsp_in.status = ST_NEW;
               end
               state_in = B_OUT;
            end else if (rd_ff[KW-1:10] == {job_ff.req.key_package, job_ff.req.key_entry}) begin
               if (job_ff.req.opcode == OP_INSERT) begin
                  wr_en = 1'b1;
                  rsp_in.status = ST_UPDATED;
               end else begin
                  rsp_in.status = ST_HIT;
                  rsp_in.found_value = rd_ff[9:0];
               end
               state_in = B_OUT;
            end else begin
               n_in = n_ff + CW'(1);
               idx_in = (idx_ff + CW'(1) >= cap) ? '0 : idx_ff + CW'(1);
               state_in = B_RD;
            end
         end
         B_OUT: begin
            if (rsp_ready) state_in = B_IDLE;
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_CLR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
      if (state_ff == B_IDLE) job_ff <= job_data;
      rem_ff <= rem_in;
      bit_ff <= bit_in;
      idx_ff <= idx_in;
      n_ff   <= n_in;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[addr] <= wr_data;
      rd_ff <= mem[addr];
   end

   `EIH_ASSERT_IMP(a_wr_in_check, clock, reset, wr_en, state_ff == B_CHK || state_ff == B_CLR)
   `EIH_ASSERT_IMP(a_idx_in_cap, clock, reset, state_ff == B_CHK && n_ff < cap, idx_ff < cap)
   `EIH_ASSERT_IMP(a_clr_quiet, clock, reset, state_ff == B_CLR, !job_ready && !rsp_valid)
endmodule

// ===== rtl/entry_id_hash_index.sv =====
// Top level of the entry id hash index: front, queue and back.
// Depends on eih_pkg, eih_front, eih_queue and eih_back.
//
//  Channel  Direction  Handshake          Payload
//  req      in         req_valid/ready    req_type
//  rsp      out        rsp_valid/ready    rsp_type
//  csr      in         csr_write_enable   table_capacity, 11 bits
//
// The front hashes a key in two multiply steps; the back loads the job, forms
// the bit-serial remainder of all 32 hash bits by the capacity, probes the
// registered slot memory in read, wait and check states, and hands over the
// response. Reset is synchronous; after it the back clears the valid marks
// of all TABLE_DEPTH slots before it takes a transaction.
// Either side may stall: the two-entry queue lets hashing run ahead.
module entry_id_hash_index import eih_pkg::*; #(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data,
   input  logic    csr_write_enable,
   input  logic [10:0] csr_write_data
);
   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = AW + 1;

   // The capacity register saturates at the table depth.
   logic [CW-1:0] cap_ff, cap_in;
   logic          fj_valid, fj_ready, bj_valid, bj_ready;
   job_type       fj_data, bj_data;
   logic [31:0]   wide_data;

   assign wide_data = {21'd0, csr_write_data};
   assign cap_in = (wide_data > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : wide_data[CW-1:0];

   always_ff @(posedge clock) begin
      if (reset) cap_ff <= CW'(TABLE_DEPTH > 1024 ? 1024 : TABLE_DEPTH);
      else if (csr_write_enable) cap_ff <= cap_in;
   end

   eih_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .job_valid(fj_valid), .job_ready(fj_ready), .job_data(fj_data)
   );

   eih_queue u_queue (
      .clock, .reset, .in_valid(fj_valid), .in_ready(fj_ready), .in_data(fj_data),
      .out_valid(bj_valid), .out_ready(bj_ready), .out_data(bj_data)
   );

   eih_back #(.DEPTH(TABLE_DEPTH), .AW(AW), .CW(CW)) u_back (
      .clock, .reset, .cap(cap_ff), .job_valid(bj_valid), .job_ready(bj_ready),
      .job_data(bj_data), .rsp_valid, .rsp_ready, .rsp_data
   );
endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the entry id hash index (entry_id_hash_index).
// Depends on eih_pkg and the block's RTL; a scoreboard class predicts each result.

module tb;
   import eih_pkg::*;

   localparam int DEPTH      = 1024;
   localparam int LIMIT      = 20000000;
   localparam int DRAIN_WAIT = 200;

   // Scoreboard: holds its own copy of the table and capacity, and a queue of
   // predicted responses, one per accepted request transaction.
   class hash_index_scoreboard;
      int unsigned capacity;
      bit          occupied [DEPTH];
      logic [31:0] held_package [DEPTH];
      logic [31:0] held_entry [DEPTH];
      logic [9:0]  held_value [DEPTH];
      rsp_type     pending [$];
      int          errors;

      function new();
         capacity = DEPTH;
         errors   = 0;
         foreach (occupied[i]) occupied[i] = 1'b0;
      endfunction

      function void set_capacity(logic [10:0] v);
         capacity = (v > DEPTH) ? DEPTH : v;
      endfunction

      function logic [31:0] key_hash(logic [31:0] p, logic [31:0] e);
         logic [31:0] h;
         h = (HASH_START ^ p) * HASH_PRIME;
         h = (h ^ e) * HASH_PRIME;
         return h;
      endfunction

      // Walks the probe chain, updates the table for an insert and queues the predicted response.
      function void note_request(req_type r);
         rsp_type     res;
         int unsigned slot;
         res.status      = (r.opcode == OP_INSERT) ? ST_FULL : ST_MISS;
         res.found_value = '0;
         if (capacity > 0) begin
            slot = key_hash(r.key_package, r.key_entry) % capacity;
            for (int n = 0; n < capacity; n++) begin
               if (!occupied[slot]) begin
                  if (r.opcode == OP_INSERT) begin
                     occupied[slot]     = 1'b1;
                     held_package[slot] = r.key_package;
                     held_entry[slot]   = r.key_entry;
                     held_value[slot]   = r.store_value;
                     res.status         = ST_NEW;
                  end
                  break;
               end
               if (held_package[slot] == r.key_package && held_entry[slot] == r.key_entry) begin
                  if (r.opcode == OP_INSERT) begin
                     held_value[slot] = r.store_value;
                     res.status       = ST_UPDATED;
                  end else begin
                     res.status      = ST_HIT;
                     res.found_value = held_value[slot];
                  end
                  break;
               end
               slot = (slot + 1 == capacity) ? 0 : slot + 1;
            end
         end
         pending.push_back(res);
      endfunction

      task report(string msg);
         $display("mismatch at %0t: %s", $time, msg);
         errors++;
      endtask

      task check_response(rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            report("response with nothing expected");
            return;
         end
         want = pending.pop_front();
         if (got.status !== want.status)
            report($sformatf("status %0d, expected %0d", got.status, want.status));
         if (got.found_value !== want.found_value)
            report($sformatf("found_value %0d, expected %0d",
                             got.found_value, want.found_value));
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_write_enable = 1'b0;
   logic [10:0] csr_write_data = '0;

   int send_idle_pct = 0;   // chance, in percent, that the sender idles a cycle
   int recv_idle_pct = 0;   // chance that the receiver stalls a cycle
   int cycles = 0;

   hash_index_scoreboard board = new();

   // Keys remembered from earlier inserts so that lookups and updates hit.
   logic [31:0] known_package [$];
   logic [31:0] known_entry [$];

   always #2 clock = ~clock;

   entry_id_hash_index uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   // Watchdog: the slowest run is roughly 800 transactions at over a thousand
   // probes with heavy stalls, so the limit is taken well above that.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= LIMIT) begin
         $display("FAIL entry_id_hash_index");
         $finish;
      end
   end

   // Sampling at the rising edge: a request transaction is predicted at the
   // edge it is accepted, so predictions follow acceptance order.
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) board.note_request(req_data);
      if (!reset && rsp_valid && rsp_ready) board.check_response(rsp_data);
   end

   // The receiver changes its ready at the falling edge, stalling at random.
   always @(negedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Presents one request and holds it until it is accepted. Valid stays high
   // to the next falling edge, where the next caller either replaces the
   // request or drops valid.
   task automatic send_request(logic op, logic [31:0] p, logic [31:0] e, logic [9:0] v);
      req_type r;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      r.opcode      = op;
      r.key_package = p;
      r.key_entry   = e;
      r.store_value = v;
      req_data  <= r;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      if (op == OP_INSERT) begin
         known_package.push_back(p);
         known_entry.push_back(e);
      end
   endtask

   // Waits until every response has arrived, then lets the back end settle.
   task automatic drain();
      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   // Capacity is written only with the block idle.
   task automatic write_capacity(logic [10:0] v);
      drain();
      csr_write_enable <= 1'b1;
      csr_write_data   <= v;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      board.set_capacity(v);
   endtask

   // Random request, mostly reusing earlier keys or keys in a narrow range so
   // that collisions, updates and hits are frequent.
   task automatic random_request();
      logic [31:0] p, e;
      int          k;
      if (known_package.size() > 0 && $urandom_range(99) < 45) begin
         k = $urandom_range(known_package.size() - 1);
         p = known_package[k];
         e = known_entry[k];
      end else if ($urandom_range(1)) begin
         p = $urandom_range(15);
         e = $urandom_range(15);
      end else begin
         p = $urandom;
         e = $urandom;
      end
      send_request(1'($urandom_range(1)), p, e, 10'($urandom_range(1023)));
   endtask

   initial begin
      logic [10:0] caps [6];
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed transactions at reset capacity: extremes of every field,
      // lookup of an empty table, insert, update and hit.
      send_request(OP_LOOKUP, 32'h0, 32'h0, 10'h0);
      send_request(OP_INSERT, 32'h0, 32'h0, 10'h3ff);
      send_request(OP_LOOKUP, 32'h0, 32'h0, 10'h155);
      send_request(OP_INSERT, 32'hffff_ffff, 32'hffff_ffff, 10'h0);
      send_request(OP_INSERT, 32'hffff_ffff, 32'hffff_ffff, 10'h2aa);
      send_request(OP_LOOKUP, 32'hffff_ffff, 32'hffff_ffff, 10'h3ff);
      send_request(OP_LOOKUP, 32'haaaa_aaaa, 32'h5555_5555, 10'h0);

      // Zero capacity: lookups miss and inserts are dropped.
      write_capacity(11'd0);
      send_request(OP_INSERT, 32'h1, 32'h2, 10'h7);
      send_request(OP_LOOKUP, 32'h0, 32'h0, 10'h0);

      // Capacity of one fills at once; the next new key finds the table full.
      write_capacity(11'd1);
      send_request(OP_INSERT, 32'h1, 32'h2, 10'h7);
      send_request(OP_INSERT, 32'h3, 32'h4, 10'h8);
      send_request(OP_LOOKUP, 32'h3, 32'h4, 10'h0);
      send_request(OP_INSERT, 32'h1, 32'h2, 10'h9);

      // Writes above the depth saturate; old keys survive a capacity change.
      write_capacity(11'h7ff);
      send_request(OP_LOOKUP, 32'h0, 32'h0, 10'h0);
      send_request(OP_LOOKUP, 32'h1, 32'h2, 10'h0);
      write_capacity(11'd3);
      for (int i = 0; i < 5; i++) send_request(OP_INSERT, 32'(i), ~32'(i), 10'(i));
      send_request(OP_LOOKUP, 32'h4, ~32'h4, 10'h0);

      // Random part in three idling phases, cycling through several capacities.
      caps = '{11'd4, 11'd1024, 11'd17, 11'd2, 11'd300, 11'd1025};
      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 6 : (ph == 1) ? 82 : 0;
         recv_idle_pct = (ph == 0) ? 82 : (ph == 1) ? 6 : 0;
         for (int c = 0; c < 6; c++) begin
            write_capacity(caps[(c + ph) % 6]);
            for (int i = 0; i < 45; i++) random_request();
            // Once per phase, the sender holds off until every response is in.
            if (c == 2) begin
               req_valid <= 1'b0;
               while (board.pending.size() != 0) @(negedge clock);
            end
         end
      end

      drain();
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("PASS entry_id_hash_index");
      end else begin
         $display("FAIL entry_id_hash_index");
      end
      $finish;
   end
endmodule
